### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared definitions for the multi-button press counter
// Register codes, the configuration bundle, field widths and the back-end
// sequencer states.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// Defaults for the top-level parameters.
	localparam int NUM_BUTTONS_DEF = 8;
	localparam int MAX_PRESSES_DEF = 15;
	localparam int TIME_BITS_DEF   = 32;

	// Fixed field widths.
	localparam int MASK_BUTTONS = 8;
	localparam int IDX_W        = 3;
	localparam int CNT_W        = 4;
	localparam int ID_W         = 3;
	localparam int SLOT_W       = 4;
	localparam int SLOT_LIMIT   = 11;
	localparam int TIMEOUT_W    = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int QUEUE_DEPTH  = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED_MASK  = 3'd0,
		REG_INVERT_MASK   = 3'd1,
		REG_PRESS_TIMEOUT = 3'd2,
		REG_BUTTON_IDS    = 3'd3,
		REG_BYTE_SLOTS    = 3'd4
	} cfg_reg_t;

	// Configuration bundle handed to the front and back ends.
	typedef struct packed {
		logic [MASK_BUTTONS-1:0]   enabled_mask;
		logic [MASK_BUTTONS-1:0]   invert_mask;
		logic [TIMEOUT_W-1:0]      press_timeout;
		logic [MASK_BUTTONS*ID_W-1:0]   id_table;
		logic [MASK_BUTTONS*SLOT_W-1:0] slot_table;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		enabled_mask:  8'd0,
		invert_mask:   8'd0,
		press_timeout: 16'd2,
		id_table:      24'd16434824,
		slot_table:    32'hFFFF_FFFF
	};

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EVAL,
		BK_WRITE
	} back_state_t;

endpackage

### rtl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: event classifier
// Accepts pin-change items, applies the enable and invert masks, tracks the
// logical state of each button and forwards only real state changes.
// ----------------------------------------------------------------------------
module bpc_front #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
	parameter int TIME_BITS   = bpc_pkg::TIME_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic [bpc_pkg::IDX_W-1:0]             button_index,
	input  logic                                  pin_level,
	input  logic [31:0]                           time_sec,
	input  bpc_pkg::cfg_t                         cfg,
	input  logic                                  q_full,
	output logic                                  q_wr,
	output logic [bpc_pkg::IDX_W+TIME_BITS:0]     q_wdata
);
	import bpc_pkg::*;

	localparam int NB    = (NUM_BUTTONS < MASK_BUTTONS) ? NUM_BUTTONS : MASK_BUTTONS;
	localparam int SEL_W = (NB > 1) ? $clog2(NB) : 1;

	logic [NB-1:0]    pressed_q;
	logic [SEL_W-1:0] sel;
	logic             accept;
	logic             enabled;
	logic             state;
	logic             changed;

	// Classify the incoming item.
	always_comb begin
		sel     = button_index[SEL_W-1:0];
		accept  = push && !q_full;
		enabled = (32'(button_index) < NUM_BUTTONS) && cfg.enabled_mask[button_index];
		state   = pin_level ^ cfg.invert_mask[button_index];
		changed = enabled && (state != pressed_q[sel]);
		q_wr    = accept && changed;
		q_wdata = {button_index, state, time_sec[TIME_BITS-1:0]};
	end

	// Logical button state, updated on every forwarded change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= '0;
		end else if (q_wr) begin
			pressed_q[sel] <= state;
		end
	end

endmodule

### rtl/bpc_queue.sv
// ----------------------------------------------------------------------------
// bpc_queue: short first-in first-out queue
// Decouples the classifier from the press sequencer.
// ----------------------------------------------------------------------------
module bpc_queue #(
	parameter int WIDTH = 36,
	parameter int DEPTH = bpc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back: press sequencer
// Takes state changes from the queue, updates press counts and press times,
// decides on a sequence restart and builds the packed status item.
// ----------------------------------------------------------------------------
module bpc_back #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
	parameter int MAX_PRESSES = bpc_pkg::MAX_PRESSES_DEF,
	parameter int TIME_BITS   = bpc_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bpc_pkg::cfg_t                     cfg,
	input  logic                              q_empty,
	output logic                              q_rd,
	input  logic [bpc_pkg::IDX_W+TIME_BITS:0] q_rdata,
	input  logic                              pop,
	output logic                              empty,
	output logic [bpc_pkg::IDX_W-1:0]         button_index_out,
	output logic [bpc_pkg::SLOT_W-1:0]        slot_index,
	output logic                              slot_valid,
	output logic [7:0]                        status_byte
);
	import bpc_pkg::*;

	localparam int NB    = (NUM_BUTTONS < MASK_BUTTONS) ? NUM_BUTTONS : MASK_BUTTONS;
	localparam int SEL_W = (NB > 1) ? $clog2(NB) : 1;
	localparam int CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

	back_state_t          state_q, state_d;
	logic [IDX_W-1:0]     b_q;
	logic                 st_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 restart_q;
	logic [CNT_W-1:0]     cnt_q  [NB];
	logic [TIME_BITS-1:0] time_q [NB];

	logic                 out_valid_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_sv_q;
	logic [7:0]           out_byte_q;

	logic [SEL_W-1:0]     sel;
	logic [TIME_BITS-1:0] mine;
	logic [TIME_BITS-1:0] age_mine;
	logic [NB-1:0]        hit;
	logic                 restart_d;
	logic [CNT_W-1:0]     cnt_cur;
	logic [CNT_W-1:0]     cnt_inc;
	logic [CNT_W-1:0]     new_cnt;
	logic [ID_W-1:0]      id;
	logic [SLOT_W-1:0]    slot;
	logic                 out_ok;
	logic                 do_write;

	// Restart decision: first press, own timeout and later presses of other buttons.
	always_comb begin
		logic [TIME_BITS-1:0] age_j;
		sel      = b_q[SEL_W-1:0];
		mine     = time_q[sel];
		age_mine = now_q - mine;
		for (int j = 0; j < NB; j++) begin
			age_j  = now_q - time_q[j];
			hit[j] = (IDX_W'(j) != b_q) && cfg.enabled_mask[j] && (time_q[j] != '0) &&
				(time_q[j] > mine) &&
				(CMP_W'(age_j) < CMP_W'(cfg.press_timeout));
		end
		restart_d = (mine == '0) ||
			(CMP_W'(age_mine) > CMP_W'(cfg.press_timeout)) ||
			((mine != '0) && (|hit));
	end

	// New count and report fields.
	always_comb begin
		cnt_cur = cnt_q[sel];
		cnt_inc = (cnt_cur < CNT_W'(MAX_PRESSES)) ? cnt_cur + 1'b1 : cnt_cur;
		if (!st_q) begin
			new_cnt = cnt_cur;
		end else if (restart_q) begin
			new_cnt = CNT_W'(1);
		end else begin
			new_cnt = cnt_inc;
		end
		id   = cfg.id_table[b_q*ID_W +: ID_W];
		slot = cfg.slot_table[b_q*SLOT_W +: SLOT_W];
	end

	// Sequencer next state.
	always_comb begin
		state_d  = state_q;
		q_rd     = 1'b0;
		do_write = 1'b0;
		out_ok   = !out_valid_q || pop;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_rd    = 1'b1;
					state_d = q_rdata[TIME_BITS] ? BK_EVAL : BK_WRITE;
				end
			end
			BK_EVAL: begin
				state_d = BK_WRITE;
			end
			BK_WRITE: begin
				if (out_ok) begin
					do_write = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item registers.
	always_ff @(posedge clk) begin
		if (q_rd) begin
			b_q   <= q_rdata[IDX_W+TIME_BITS:TIME_BITS+1];
			st_q  <= q_rdata[TIME_BITS];
			now_q <= q_rdata[TIME_BITS-1:0];
		end
		if (state_q == BK_EVAL) begin
			restart_q <= restart_d;
		end
	end

	// Per-button counts and press times.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NB; j++) begin
				cnt_q[j]  <= '0;
				time_q[j] <= '0;
			end
		end else if (do_write && st_q) begin
			if (restart_q) begin
				for (int j = 0; j < NB; j++) begin
					if (cfg.enabled_mask[j]) begin
						cnt_q[j] <= '0;
					end
				end
			end
			cnt_q[sel]  <= new_cnt;
			time_q[sel] <= now_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_write) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			out_idx_q  <= b_q;
			out_slot_q <= slot;
			out_sv_q   <= (32'(slot) < SLOT_LIMIT);
			out_byte_q <= {st_q, new_cnt, id};
		end
	end

	assign empty            = !out_valid_q;
	assign button_index_out = out_idx_q;
	assign slot_index       = out_slot_q;
	assign slot_valid       = out_sv_q;
	assign status_byte      = out_byte_q;

endmodule

### rtl/multi_button_press_counter_core.sv
// ----------------------------------------------------------------------------
// multi_button_press_counter_core: multi-button press counter
// Counts repeated presses per button and reports a packed status byte.
// ----------------------------------------------------------------------------
// Pin-change items enter through a queue interface (push/full) and status
// items leave through another (empty/pop). The classifier takes one item per
// cycle while the queue has room and drops items of disabled buttons or
// without a change of logical state; changes pass through a two-entry queue
// to the press sequencer. The sequencer goes through read and write-back for
// a release and read, restart evaluation against the press times of all
// buttons and write-back for a press, and ends one change before it reads the
// next. A result waits in an output register while the next change is already
// being worked on. Configuration writes are always accepted (cfg_ready is
// high) and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module multi_button_press_counter_core #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
	parameter int MAX_PRESSES = bpc_pkg::MAX_PRESSES_DEF,
	parameter int TIME_BITS   = bpc_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [bpc_pkg::IDX_W-1:0]          button_index,
	input  logic                               pin_level,
	input  logic [31:0]                        time_sec,
	output logic                               empty,
	input  logic                               pop,
	output logic [bpc_pkg::IDX_W-1:0]          button_index_out,
	output logic [bpc_pkg::SLOT_W-1:0]         slot_index,
	output logic                               slot_valid,
	output logic [7:0]                         status_byte,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bpc_pkg::*;

	localparam int EVT_W = IDX_W + 1 + TIME_BITS;

	cfg_t             cfg_q;
	logic             q_wr;
	logic             q_rd;
	logic             q_empty;
	logic [EVT_W-1:0] q_wdata;
	logic [EVT_W-1:0] q_rdata;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ENABLED_MASK:  cfg_q.enabled_mask  <= cfg_data[MASK_BUTTONS-1:0];
				REG_INVERT_MASK:   cfg_q.invert_mask   <= cfg_data[MASK_BUTTONS-1:0];
				REG_PRESS_TIMEOUT: cfg_q.press_timeout <= cfg_data[TIMEOUT_W-1:0];
				REG_BUTTON_IDS:    cfg_q.id_table      <= cfg_data[MASK_BUTTONS*ID_W-1:0];
				REG_BYTE_SLOTS:    cfg_q.slot_table    <= cfg_data[MASK_BUTTONS*SLOT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Classifier.
	bpc_front #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.TIME_BITS  (TIME_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.button_index(button_index),
		.pin_level   (pin_level),
		.time_sec    (time_sec),
		.cfg         (cfg_q),
		.q_full      (full),
		.q_wr        (q_wr),
		.q_wdata     (q_wdata)
	);

	// Queue between classifier and sequencer.
	bpc_queue #(
		.WIDTH(EVT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wdata (q_wdata),
		.full  (full),
		.rd    (q_rd),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	// Press sequencer.
	bpc_back #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.MAX_PRESSES(MAX_PRESSES),
		.TIME_BITS  (TIME_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (q_empty),
		.q_rd            (q_rd),
		.q_rdata         (q_rdata),
		.pop             (pop),
		.empty           (empty),
		.button_index_out(button_index_out),
		.slot_index      (slot_index),
		.slot_valid      (slot_valid),
		.status_byte     (status_byte)
	);

endmodule

### rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks for the press counter
// Watches the top-level ports and flags results that break the contract.
// ----------------------------------------------------------------------------
module bpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           push,
	input logic                           full,
	input logic                           empty,
	input logic                           pop,
	input logic [bpc_pkg::IDX_W-1:0]      button_index_out,
	input logic [bpc_pkg::SLOT_W-1:0]     slot_index,
	input logic                           slot_valid,
	input logic [7:0]                     status_byte
);
	import bpc_pkg::*;

	logic [7:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	// Items accepted but not yet matched by a result (saturating).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			if (pend_q != 8'hFF) begin
				pend_q <= pend_q + 1'b1;
			end
		end else if (out_acc && !in_acc) begin
			if (pend_q != 8'h00) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	// A result never appears without an item accepted before it.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (pend_q != 8'h00))
		else $error("result taken without a matching item");

	// The slot flag follows the slot index.
	a_slot_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (slot_valid == (32'(slot_index) < SLOT_LIMIT)))
		else $error("slot_valid does not match slot_index");

	// A pressed button always reports at least one press.
	a_press_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status_byte[7]) |-> (status_byte[6:3] != 4'd0))
		else $error("pressed button with zero count");

	// A waiting result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status_byte) &&
			$stable(button_index_out) && $stable(slot_index)))
		else $error("waiting result changed");

endmodule

bind multi_button_press_counter_core bpc_checker u_bpc_checker (.*);
